// File: sv/vasd_pkg.sv
package vasd_pkg;

  // Steering limit and direction
  localparam int unsigned MAX_STEER = 7680;
  localparam bit INVERT = 1'b0;

  // Field and datapath widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned STEER_W = 16;
  localparam int unsigned US_W = 16;
  localparam int unsigned SPAN_W = 15;
  localparam int unsigned MS_W = 16;
  localparam int unsigned PAT_W = 15;
  localparam int unsigned SRC_W = 16;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Serial servo path: offset steer times span, then numerator for the divide
  localparam int unsigned OPA_W = 16;
  localparam int unsigned PROD_W = OPA_W + SPAN_W;
  localparam int unsigned NUM_W = PROD_W + 2;
  localparam int unsigned QUO_W = 17;
  localparam int unsigned SUM_W = 19;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned MUL_STEPS = SPAN_W;
  localparam int unsigned DIV_LAST = MUL_STEPS + NUM_W;

  localparam logic signed [STEER_W-1:0] STEER_LIM = STEER_W'(MAX_STEER);
  localparam logic [OPA_W-1:0] STEER_DIV = OPA_W'(2 * MAX_STEER);
  localparam logic [NUM_W-1:0] STEER_BIAS = NUM_W'(MAX_STEER);

  // Heartbeat and fault blink moduli
  localparam int unsigned RUN_W = 10;
  localparam int unsigned FLT_W = 9;
  localparam logic [RUN_W-1:0] RUN_PERIOD = RUN_W'(1000);
  localparam logic [RUN_W-1:0] RUN_ON = RUN_W'(500);
  localparam logic [FLT_W-1:0] FLT_PERIOD = FLT_W'(500);
  localparam logic [FLT_W-1:0] FLT_ON = FLT_W'(250);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_MID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_SPAN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHIRP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_ON = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_OFF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEGR_ON = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEGR_OFF = 3'd7;

  // Configuration reset values
  localparam logic [US_W-1:0] RST_SERVO_MID = 16'd1500;
  localparam logic [SPAN_W-1:0] RST_SERVO_SPAN = 15'd500;
  localparam logic [MS_W-1:0] RST_BLINK_HALF = 16'd400;
  localparam logic [MS_W-1:0] RST_CHIRP = 16'd150;
  localparam logic [PAT_W-1:0] RST_CRIT_ON = 15'd100;
  localparam logic [PAT_W-1:0] RST_CRIT_OFF = 15'd100;
  localparam logic [PAT_W-1:0] RST_DEGR_ON = 15'd800;
  localparam logic [PAT_W-1:0] RST_DEGR_OFF = 15'd400;

  // System modes
  localparam logic [MODE_W-1:0] MODE_EBRAKE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FAILSAFE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FAULT_LOCK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEGRADED = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MIN_RISK = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    BZ_NONE,
    BZ_CRIT,
    BZ_DEGR
  } buzz_sel_t;

  // Control strobes to a serial unit
  typedef struct packed {
    logic clear;
    logic step;
  } step_ctl_t;

endpackage

// File: sv/vasd_rem_lane.sv
module vasd_rem_lane #(
  parameter int unsigned W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vasd_pkg::step_ctl_t  ctl,
  input  logic                 din,
  input  logic [W-1:0]         divisor,
  output logic [W-1:0]         rem,
  output logic                 qbit
);

  logic [W:0] shifted;
  logic [W:0] diff;

  // Shift in one dividend bit and try a subtract
  always_comb begin
    shifted = {rem, din};
    diff = shifted - {1'b0, divisor};
    qbit = (shifted >= {1'b0, divisor});
  end

  // Hold the partial remainder
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      rem <= '0;
    end else if (ctl.step) begin
      rem <= qbit ? diff[W-1:0] : shifted[W-1:0];
    end
  end

endmodule

// File: sv/vasd_ser_mul.sv
module vasd_ser_mul (
  input  logic                               clk,
  input  vasd_pkg::step_ctl_t                ctl,
  input  logic [vasd_pkg::OPA_W-1:0]         opa,
  input  logic [vasd_pkg::SPAN_W-1:0]        opb,
  output logic [vasd_pkg::PROD_W-1:0]        prod
);

  logic [vasd_pkg::PROD_W-1:0] a_sh;
  logic [vasd_pkg::SPAN_W-1:0] b_sh;

  // Add the shifted multiplicand for each multiplier bit, low bit first
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      prod <= '0;
      a_sh <= {{(vasd_pkg::PROD_W - vasd_pkg::OPA_W){1'b0}}, opa};
      b_sh <= opb;
    end else if (ctl.step) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= {a_sh[vasd_pkg::PROD_W-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[vasd_pkg::SPAN_W-1:1]};
    end
  end

endmodule

// File: sv/vehicle_annunciator_servo_drive.sv
// Vehicle annunciator and servo drive. Each accepted request yields one result: a servo
// pulse width (clamped steer mapped linearly around servo_center_us, rounded half up,
// saturated to 16 bits), the turn lamps, the buzzer (critical, then degraded, then
// chirp) and the run and fault LEDs. A request passes from accept through a bit-serial
// multiply, a load step, a bit-serial divide and a finish step that updates state and
// the result register, then returns to the idle state, which takes the next request.
// The three modulo lanes on now_ms run one bit a cycle
// alongside the multiply and divide. A finished result waits in the output register;
// the block holds its last step while that register is stalled. Configuration writes
// take effect at once and belong between requests.
module vehicle_annunciator_servo_drive (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vasd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vasd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [vasd_pkg::TIME_W-1:0]          now_ms,
  input  logic signed [vasd_pkg::STEER_W-1:0]  steer,
  input  logic                                 hazard,
  input  logic                                 left_turn,
  input  logic                                 right_turn,
  input  logic                                 estop,
  input  logic                                 aeb_floor,
  input  logic                                 degraded,
  input  logic [vasd_pkg::MODE_W-1:0]          system_mode,
  input  logic [vasd_pkg::SRC_W-1:0]           source_id,
  input  logic                                 chirp_request,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [vasd_pkg::US_W-1:0]            servo_us,
  output logic                                 light_left,
  output logic                                 light_right,
  output logic                                 buzzer_on,
  output logic                                 run_led,
  output logic                                 fault_led
);

  // Configuration registers
  logic [vasd_pkg::US_W-1:0]   servo_center_us;
  logic [vasd_pkg::SPAN_W-1:0] servo_half_span_us;
  logic [vasd_pkg::MS_W-1:0]   blink_half_ms;
  logic [vasd_pkg::MS_W-1:0]   chirp_ms;
  logic [vasd_pkg::PAT_W-1:0]  critical_on_ms;
  logic [vasd_pkg::PAT_W-1:0]  critical_off_ms;
  logic [vasd_pkg::PAT_W-1:0]  degraded_on_ms;
  logic [vasd_pkg::PAT_W-1:0]  degraded_off_ms;

  // Block state
  logic [vasd_pkg::TIME_W-1:0] blink_ref;
  logic                        blink_phase;
  logic [vasd_pkg::TIME_W-1:0] chirp_end;
  logic                        chirp_on;
  logic [vasd_pkg::SRC_W-1:0]  prev_source;
  logic                        source_valid;

  // Sequencer
  vasd_pkg::state_t            state;
  vasd_pkg::state_t            state_next;
  logic [vasd_pkg::CNT_W-1:0]  cnt;
  logic                        accept;
  logic                        finish;
  logic                        mod_step;
  vasd_pkg::step_ctl_t         mod_ctl;
  vasd_pkg::step_ctl_t         mul_ctl;
  vasd_pkg::step_ctl_t         div_ctl;

  // Request latched at accept
  logic [vasd_pkg::TIME_W-1:0] now_l;
  logic [vasd_pkg::TIME_W-1:0] now_sr;
  logic                        hazard_l;
  logic                        left_turn_l;
  logic                        right_turn_l;
  logic                        fault_hard_l;
  logic                        fault_soft_l;
  logic                        chirp_start_l;
  vasd_pkg::buzz_sel_t         buzz_sel_l;
  logic [vasd_pkg::PAT_W-1:0]  pat_on_l;
  logic [vasd_pkg::MS_W-1:0]   period_l;

  // Request decode
  logic signed [vasd_pkg::STEER_W-1:0] steer_lim;
  logic signed [vasd_pkg::STEER_W-1:0] steer_dir;
  logic [vasd_pkg::OPA_W:0]            steer_off;
  logic                                is_crit;
  logic                                is_degr;

  // Serial datapath
  logic [vasd_pkg::PROD_W-1:0] prod;
  logic [vasd_pkg::NUM_W-1:0]  num_sr;
  logic [vasd_pkg::QUO_W-1:0]  quo;
  logic [vasd_pkg::OPA_W-1:0]  div_rem;
  logic                        div_qbit;
  logic [vasd_pkg::MS_W-1:0]   pat_rem;
  logic                        pat_qbit;
  logic [vasd_pkg::RUN_W-1:0]  run_rem;
  logic                        run_qbit;
  logic [vasd_pkg::FLT_W-1:0]  flt_rem;
  logic                        flt_qbit;

  // Finish-step values
  logic signed [vasd_pkg::SUM_W-1:0] servo_sum;
  logic [vasd_pkg::US_W-1:0]         servo_sat;
  logic [vasd_pkg::TIME_W-1:0]       blink_age;
  logic                              blink_toggle;
  logic                              phase_next;
  logic                              chirp_on_next;
  logic [vasd_pkg::TIME_W-1:0]       chirp_end_next;
  logic [vasd_pkg::TIME_W-1:0]       chirp_left;
  logic                              chirp_active;
  logic                              pat_buzz;
  logic                              buzz_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_center_us <= vasd_pkg::RST_SERVO_MID;
      servo_half_span_us <= vasd_pkg::RST_SERVO_SPAN;
      blink_half_ms <= vasd_pkg::RST_BLINK_HALF;
      chirp_ms <= vasd_pkg::RST_CHIRP;
      critical_on_ms <= vasd_pkg::RST_CRIT_ON;
      critical_off_ms <= vasd_pkg::RST_CRIT_OFF;
      degraded_on_ms <= vasd_pkg::RST_DEGR_ON;
      degraded_off_ms <= vasd_pkg::RST_DEGR_OFF;
    end else if (cfg_we) begin
      case (cfg_index)
        vasd_pkg::REG_SERVO_MID:  servo_center_us <= cfg_data;
        vasd_pkg::REG_SERVO_SPAN: servo_half_span_us <= cfg_data[vasd_pkg::SPAN_W-1:0];
        vasd_pkg::REG_BLINK_HALF: blink_half_ms <= cfg_data;
        vasd_pkg::REG_CHIRP:      chirp_ms <= cfg_data;
        vasd_pkg::REG_CRIT_ON:    critical_on_ms <= cfg_data[vasd_pkg::PAT_W-1:0];
        vasd_pkg::REG_CRIT_OFF:   critical_off_ms <= cfg_data[vasd_pkg::PAT_W-1:0];
        vasd_pkg::REG_DEGR_ON:    degraded_on_ms <= cfg_data[vasd_pkg::PAT_W-1:0];
        vasd_pkg::REG_DEGR_OFF:   degraded_off_ms <= cfg_data[vasd_pkg::PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp, orient and offset the steer for a non-negative multiply operand; decode alarms
  always_comb begin
    if (steer > vasd_pkg::STEER_LIM) begin
      steer_lim = vasd_pkg::STEER_LIM;
    end else if (steer < -vasd_pkg::STEER_LIM) begin
      steer_lim = -vasd_pkg::STEER_LIM;
    end else begin
      steer_lim = steer;
    end
    steer_dir = vasd_pkg::INVERT ? -steer_lim : steer_lim;
    steer_off = {steer_dir[vasd_pkg::STEER_W-1], steer_dir}
                + (vasd_pkg::OPA_W + 1)'(vasd_pkg::MAX_STEER);
    is_crit = estop || aeb_floor || (system_mode inside {vasd_pkg::MODE_EBRAKE,
              vasd_pkg::MODE_FAILSAFE, vasd_pkg::MODE_FAULT_LOCK});
    is_degr = degraded || (system_mode inside {vasd_pkg::MODE_DEGRADED,
              vasd_pkg::MODE_MIN_RISK});
  end

  // Advance the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vasd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit strobes
  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    accept = 1'b0;
    finish = 1'b0;
    mul_ctl = '0;
    div_ctl = '0;
    mod_step = 1'b0;
    case (state)
      vasd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept = in_valid;
        if (in_valid) begin
          state_next = vasd_pkg::ST_MUL;
        end
      end
      vasd_pkg::ST_MUL: begin
        mul_ctl.step = 1'b1;
        mod_step = 1'b1;
        if (cnt == vasd_pkg::CNT_W'(vasd_pkg::MUL_STEPS - 1)) begin
          state_next = vasd_pkg::ST_LOAD;
        end
      end
      vasd_pkg::ST_LOAD: begin
        div_ctl.clear = 1'b1;
        mod_step = 1'b1;
        state_next = vasd_pkg::ST_DIV;
      end
      vasd_pkg::ST_DIV: begin
        div_ctl.step = 1'b1;
        mod_step = (cnt < vasd_pkg::CNT_W'(vasd_pkg::TIME_W));
        if (cnt == vasd_pkg::CNT_W'(vasd_pkg::DIV_LAST)) begin
          state_next = vasd_pkg::ST_DONE;
        end
      end
      vasd_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          finish = 1'b1;
          state_next = vasd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vasd_pkg::ST_IDLE;
      end
    endcase
    mul_ctl.clear = accept;
    mod_ctl.clear = accept;
    mod_ctl.step = mod_step;
  end

  // Count steps of one request
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      cnt <= '0;
    end else if (state != vasd_pkg::ST_IDLE && state != vasd_pkg::ST_DONE) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Latch the request and track the source
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_source <= '0;
      source_valid <= 1'b0;
    end else if (accept) begin
      prev_source <= source_id;
      source_valid <= 1'b1;
    end
    if (accept) begin
      now_l <= now_ms;
      hazard_l <= hazard;
      left_turn_l <= left_turn;
      right_turn_l <= right_turn;
      fault_hard_l <= estop || aeb_floor;
      fault_soft_l <= degraded;
      chirp_start_l <= chirp_request || (source_valid && (source_id != prev_source));
      if (is_crit) begin
        buzz_sel_l <= vasd_pkg::BZ_CRIT;
        pat_on_l <= critical_on_ms;
        period_l <= {1'b0, critical_on_ms} + {1'b0, critical_off_ms};
      end else if (is_degr) begin
        buzz_sel_l <= vasd_pkg::BZ_DEGR;
        pat_on_l <= degraded_on_ms;
        period_l <= {1'b0, degraded_on_ms} + {1'b0, degraded_off_ms};
      end else begin
        buzz_sel_l <= vasd_pkg::BZ_NONE;
        pat_on_l <= '0;
        period_l <= '0;
      end
    end
  end

  // Shift the time out high bit first into the modulo lanes
  always_ff @(posedge clk) begin
    if (accept) begin
      now_sr <= now_ms;
    end else if (mod_step) begin
      now_sr <= {now_sr[vasd_pkg::TIME_W-2:0], 1'b0};
    end
  end

  // Load the numerator, then shift it into the divide and collect quotient bits
  always_ff @(posedge clk) begin
    if (div_ctl.clear) begin
      num_sr <= {1'b0, prod, 1'b0} + vasd_pkg::STEER_BIAS;
      quo <= '0;
    end else if (div_ctl.step) begin
      num_sr <= {num_sr[vasd_pkg::NUM_W-2:0], 1'b0};
      quo <= {quo[vasd_pkg::QUO_W-2:0], div_qbit};
    end
  end

  // The multiply loads at the accept edge the offset steer from the request and the half span
  vasd_ser_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .opa  (steer_off[vasd_pkg::OPA_W-1:0]),
    .opb  (servo_half_span_us),
    .prod (prod)
  );

  vasd_rem_lane #(.W(vasd_pkg::OPA_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (div_ctl),
    .din     (num_sr[vasd_pkg::NUM_W-1]),
    .divisor (vasd_pkg::STEER_DIV),
    .rem     (div_rem),
    .qbit    (div_qbit)
  );

  vasd_rem_lane #(.W(vasd_pkg::MS_W)) u_pat (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mod_ctl),
    .din     (now_sr[vasd_pkg::TIME_W-1]),
    .divisor (period_l),
    .rem     (pat_rem),
    .qbit    (pat_qbit)
  );

  vasd_rem_lane #(.W(vasd_pkg::RUN_W)) u_run (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mod_ctl),
    .din     (now_sr[vasd_pkg::TIME_W-1]),
    .divisor (vasd_pkg::RUN_PERIOD),
    .rem     (run_rem),
    .qbit    (run_qbit)
  );

  vasd_rem_lane #(.W(vasd_pkg::FLT_W)) u_flt (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mod_ctl),
    .din     (now_sr[vasd_pkg::TIME_W-1]),
    .divisor (vasd_pkg::FLT_PERIOD),
    .rem     (flt_rem),
    .qbit    (flt_qbit)
  );

  // Remove the offset, saturate the width, and work out lamps, chirp and buzzer
  always_comb begin
    servo_sum = $signed({3'b0, servo_center_us}) + $signed({2'b0, quo})
                - $signed({4'b0, servo_half_span_us});
    if (servo_sum[vasd_pkg::SUM_W-1]) begin
      servo_sat = '0;
    end else if (servo_sum[vasd_pkg::SUM_W-2:vasd_pkg::US_W] != '0) begin
      servo_sat = '1;
    end else begin
      servo_sat = servo_sum[vasd_pkg::US_W-1:0];
    end

    blink_age = now_l - blink_ref;
    blink_toggle = (blink_age >= {{(vasd_pkg::TIME_W - vasd_pkg::MS_W){1'b0}}, blink_half_ms});
    phase_next = blink_toggle ? !blink_phase : blink_phase;

    chirp_end_next = chirp_start_l
                     ? now_l + {{(vasd_pkg::TIME_W - vasd_pkg::MS_W){1'b0}}, chirp_ms}
                     : chirp_end;
    chirp_active = chirp_start_l || chirp_on;
    chirp_left = now_l - chirp_end;
    pat_buzz = (period_l != '0) && (pat_rem < {1'b0, pat_on_l});

    chirp_on_next = chirp_active;
    buzz_next = 1'b0;
    case (buzz_sel_l)
      vasd_pkg::BZ_CRIT, vasd_pkg::BZ_DEGR: begin
        buzz_next = pat_buzz;
      end
      vasd_pkg::BZ_NONE: begin
        // a chirp started by this request is already over only when its length is zero
        if (chirp_active) begin
          if (chirp_start_l) begin
            chirp_on_next = (chirp_ms != '0);
          end else begin
            chirp_on_next = chirp_left[vasd_pkg::TIME_W-1];
          end
        end
        buzz_next = chirp_on_next;
      end
      default: ;
    endcase
  end

  // Commit blink and chirp state at the end of a request
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_ref <= '0;
      blink_phase <= 1'b0;
      chirp_end <= '0;
      chirp_on <= 1'b0;
    end else if (finish) begin
      if (blink_toggle) begin
        blink_ref <= now_l;
      end
      blink_phase <= phase_next;
      chirp_end <= chirp_end_next;
      chirp_on <= chirp_on_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (finish) begin
      servo_us <= servo_sat;
      light_left <= (hazard_l || left_turn_l) && phase_next;
      light_right <= (hazard_l || right_turn_l) && phase_next;
      buzzer_on <= buzz_next;
      run_led <= (run_rem < vasd_pkg::RUN_ON);
      fault_led <= fault_hard_l || (fault_soft_l && (flt_rem < vasd_pkg::FLT_ON));
    end
  end

`ifndef NO_ASSERTIONS
  // A new result appears only out of the finish step
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == vasd_pkg::ST_DONE))
    else $error("result raised outside the finish step");

  // An accepted request starts the multiply with a cleared step count
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == vasd_pkg::ST_MUL && cnt == '0))
    else $error("accepted request did not start the multiply");

  // The fixed modulo lanes stay below their moduli
  a_lane_bound: assert property (@(posedge clk) disable iff (rst)
    (run_rem < vasd_pkg::RUN_PERIOD) && (flt_rem < vasd_pkg::FLT_PERIOD))
    else $error("modulo lane out of range");

  // The servo quotient never exceeds twice the span
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (state == vasd_pkg::ST_DONE) |-> (quo <= {1'b0, servo_half_span_us, 1'b0}))
    else $error("servo quotient out of range");
`endif

endmodule

// File: tb/tb_vehicle_annunciator_servo_drive.sv
module tb_vehicle_annunciator_servo_drive;

  localparam int QUIET_LIMIT = 4000;

  // One update request and the drive result it produces
  typedef struct {
    logic [vasd_pkg::TIME_W-1:0]         now;
    logic signed [vasd_pkg::STEER_W-1:0] steer;
    bit                                  hazard;
    bit                                  left_turn;
    bit                                  right_turn;
    bit                                  estop;
    bit                                  aeb;
    bit                                  degraded;
    logic [vasd_pkg::MODE_W-1:0]         mode;
    logic [vasd_pkg::SRC_W-1:0]          src;
    bit                                  req;
  } update_t;

  typedef struct {
    logic [vasd_pkg::US_W-1:0] servo_us;
    bit                        light_left;
    bit                        light_right;
    bit                        buzzer_on;
    bit                        run_led;
    bit                        fault_led;
  } drive_result_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  cfg_we;
  logic [vasd_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [vasd_pkg::CFG_DATA_W-1:0]       cfg_data;
  logic                                  in_valid;
  logic                                  in_stall;
  logic [vasd_pkg::TIME_W-1:0]           now_ms;
  logic signed [vasd_pkg::STEER_W-1:0]   steer;
  logic                                  hazard;
  logic                                  left_turn;
  logic                                  right_turn;
  logic                                  estop;
  logic                                  aeb_floor;
  logic                                  degraded;
  logic [vasd_pkg::MODE_W-1:0]           system_mode;
  logic [vasd_pkg::SRC_W-1:0]            source_id;
  logic                                  chirp_request;
  logic                                  out_valid;
  logic                                  out_stall;
  logic [vasd_pkg::US_W-1:0]             servo_us;
  logic                                  light_left;
  logic                                  light_right;
  logic                                  buzzer_on;
  logic                                  run_led;
  logic                                  fault_led;

  // Register copies held by the predictor
  logic [vasd_pkg::US_W-1:0]   mid_us;
  logic [vasd_pkg::SPAN_W-1:0] half_span;
  logic [vasd_pkg::MS_W-1:0]   blink_half;
  logic [vasd_pkg::MS_W-1:0]   chirp_len;
  logic [vasd_pkg::PAT_W-1:0]  crit_on;
  logic [vasd_pkg::PAT_W-1:0]  crit_off;
  logic [vasd_pkg::PAT_W-1:0]  degr_on;
  logic [vasd_pkg::PAT_W-1:0]  degr_off;

  // Annunciator state held by the predictor
  logic [vasd_pkg::TIME_W-1:0] blink_ref;
  bit                          blink_phase;
  logic [vasd_pkg::TIME_W-1:0] chirp_end;
  bit                          chirp_on;
  logic [vasd_pkg::SRC_W-1:0]  prev_src;
  bit                          source_seen;

  drive_result_t pending_results[$];
  drive_result_t want;

  int mismatches;
  int updates_sent;
  int results_checked;
  int register_sets;
  int quiet_cycles;
  int stall_tick;

  // Stimulus shaping
  logic [vasd_pkg::TIME_W-1:0] cur_now;
  logic [vasd_pkg::SRC_W-1:0]  cur_src;
  bit                          sender_gaps;
  int                          burst_left;
  int                          alarm_pct;
  int                          step_max;

  vehicle_annunciator_servo_drive i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit pattern_on(logic [vasd_pkg::TIME_W-1:0] now,
                                    logic [vasd_pkg::PAT_W-1:0] on,
                                    logic [vasd_pkg::PAT_W-1:0] off);
    logic [vasd_pkg::TIME_W-1:0] period;
    period = vasd_pkg::TIME_W'(on) + vasd_pkg::TIME_W'(off);
    if (period == '0) return 1'b0;
    return (now % period) < vasd_pkg::TIME_W'(on);
  endfunction

  // Advance the annunciator state by one update and form its drive result
  function automatic drive_result_t predict_update(update_t u);
    drive_result_t               r;
    logic [vasd_pkg::TIME_W-1:0] dt;
    longint                      s;
    longint                      num;
    longint                      den;
    longint                      q;
    longint                      v;
    bit                          critical;
    bit                          degr_sel;
    if (u.req) begin
      chirp_on = 1'b1;
      chirp_end = u.now + vasd_pkg::TIME_W'(chirp_len);
    end
    dt = u.now - blink_ref;
    if (dt >= vasd_pkg::TIME_W'(blink_half)) begin
      blink_ref = u.now;
      blink_phase = !blink_phase;
    end
    r.light_left = u.hazard ? blink_phase : (u.left_turn && blink_phase);
    r.light_right = u.hazard ? blink_phase : (u.right_turn && blink_phase);

    // Sample the first source; restart the chirp on any later change
    if (!source_seen) begin
      prev_src = u.src;
      source_seen = 1'b1;
    end else if (u.src != prev_src) begin
      chirp_on = 1'b1;
      chirp_end = u.now + vasd_pkg::TIME_W'(chirp_len);
      prev_src = u.src;
    end

    critical = u.estop || u.aeb || u.mode == vasd_pkg::MODE_EBRAKE ||
               u.mode == vasd_pkg::MODE_FAILSAFE || u.mode == vasd_pkg::MODE_FAULT_LOCK;
    degr_sel = u.degraded || u.mode == vasd_pkg::MODE_DEGRADED ||
               u.mode == vasd_pkg::MODE_MIN_RISK;
    r.buzzer_on = 1'b0;
    if (critical) begin
      r.buzzer_on = pattern_on(u.now, crit_on, crit_off);
    end else if (degr_sel) begin
      r.buzzer_on = pattern_on(u.now, degr_on, degr_off);
    end else if (chirp_on) begin
      dt = u.now - chirp_end;
      if (!dt[vasd_pkg::TIME_W-1]) chirp_on = 1'b0;
      r.buzzer_on = chirp_on;
    end

    if (u.estop || u.aeb) r.fault_led = 1'b1;
    else if (u.degraded) r.fault_led = (u.now % 32'd500) < 32'd250;
    else r.fault_led = 1'b0;
    r.run_led = (u.now % 32'd1000) < 32'd500;

    // Clamp steer, then round half up on the linear servo map and saturate
    s = longint'(u.steer);
    if (s > longint'(vasd_pkg::MAX_STEER)) s = longint'(vasd_pkg::MAX_STEER);
    if (s < -longint'(vasd_pkg::MAX_STEER)) s = -longint'(vasd_pkg::MAX_STEER);
    if (vasd_pkg::INVERT) s = -s;
    num = 2 * s * longint'(half_span) + longint'(vasd_pkg::MAX_STEER);
    den = 2 * longint'(vasd_pkg::MAX_STEER);
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    v = longint'(mid_us) + q;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    r.servo_us = vasd_pkg::US_W'(v);
    return r;
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_update(update_t u);
    @(negedge clk);
    in_valid <= 1'b1;
    now_ms <= u.now;
    steer <= u.steer;
    hazard <= u.hazard;
    left_turn <= u.left_turn;
    right_turn <= u.right_turn;
    estop <= u.estop;
    aeb_floor <= u.aeb;
    degraded <= u.degraded;
    system_mode <= u.mode;
    source_id <= u.src;
    chirp_request <= u.req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_update(u));
    updates_sent++;
    // End the burst with a random gap
    if (sender_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [vasd_pkg::CFG_IDX_W-1:0] idx,
                           logic [vasd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      vasd_pkg::REG_SERVO_MID:  mid_us = data;
      vasd_pkg::REG_SERVO_SPAN: half_span = data[vasd_pkg::SPAN_W-1:0];
      vasd_pkg::REG_BLINK_HALF: blink_half = data;
      vasd_pkg::REG_CHIRP:      chirp_len = data;
      vasd_pkg::REG_CRIT_ON:    crit_on = data[vasd_pkg::PAT_W-1:0];
      vasd_pkg::REG_CRIT_OFF:   crit_off = data[vasd_pkg::PAT_W-1:0];
      vasd_pkg::REG_DEGR_ON:    degr_on = data[vasd_pkg::PAT_W-1:0];
      vasd_pkg::REG_DEGR_OFF:   degr_off = data[vasd_pkg::PAT_W-1:0];
      default: ;
    endcase
  endtask

  // Drain the block, let it settle, then load all eight registers
  task automatic set_registers(logic [15:0] mid, logic [15:0] span, logic [15:0] blink,
                               logic [15:0] chirp, logic [15:0] con, logic [15:0] coff,
                               logic [15:0] don, logic [15:0] doff);
    wait_all_results();
    repeat (8) @(posedge clk);
    write_reg(vasd_pkg::REG_SERVO_MID, mid);
    write_reg(vasd_pkg::REG_SERVO_SPAN, span);
    write_reg(vasd_pkg::REG_BLINK_HALF, blink);
    write_reg(vasd_pkg::REG_CHIRP, chirp);
    write_reg(vasd_pkg::REG_CRIT_ON, con);
    write_reg(vasd_pkg::REG_CRIT_OFF, coff);
    write_reg(vasd_pkg::REG_DEGR_ON, don);
    write_reg(vasd_pkg::REG_DEGR_OFF, doff);
    @(negedge clk);
    cfg_we <= 1'b0;
    register_sets++;
  endtask

  function automatic update_t quiet_update(logic [vasd_pkg::TIME_W-1:0] now,
                                           logic [vasd_pkg::STEER_W-1:0] st,
                                           logic [vasd_pkg::SRC_W-1:0] src);
    update_t u;
    u = '{now: now, steer: st, src: src, mode: '0, default: 1'b0};
    cur_now = now;
    cur_src = src;
    return u;
  endfunction

  // Build a well-formed update: time mostly moves forward, source mostly holds
  function automatic update_t random_update();
    update_t u;
    int      mag;
    case ($urandom_range(0, 29))
      0:       cur_now = $urandom;
      1:       cur_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
      default: cur_now = cur_now + $urandom_range(0, step_max);
    endcase
    u.now = cur_now;
    case ($urandom_range(0, 9))
      0: u.steer = vasd_pkg::STEER_W'($urandom);
      1: begin
        mag = int'(vasd_pkg::MAX_STEER) - 2 + int'($urandom_range(0, 4));
        u.steer = vasd_pkg::STEER_W'($urandom_range(0, 1) ? mag : -mag);
      end
      2: u.steer = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: begin
        u.steer = vasd_pkg::STEER_W'(int'($urandom_range(0, 2 * vasd_pkg::MAX_STEER))
                                     - int'(vasd_pkg::MAX_STEER));
      end
    endcase
    u.hazard = $urandom_range(0, 99) < 15;
    u.left_turn = $urandom_range(0, 99) < 30;
    u.right_turn = $urandom_range(0, 99) < 30;
    u.estop = $urandom_range(0, 199) < alarm_pct;
    u.aeb = $urandom_range(0, 199) < alarm_pct;
    u.degraded = $urandom_range(0, 99) < alarm_pct;
    u.mode = ($urandom_range(0, 99) < alarm_pct) ? vasd_pkg::MODE_W'($urandom_range(0, 7))
                                                 : '0;
    if ($urandom_range(0, 14) == 0) cur_src = vasd_pkg::SRC_W'($urandom);
    u.src = cur_src;
    u.req = $urandom_range(0, 19) == 0;
    return u;
  endfunction

  task automatic run_updates(int count, bit gaps, int alarm, int step);
    sender_gaps = gaps;
    burst_left = $urandom_range(1, 16);
    alarm_pct = alarm;
    step_max = step;
    repeat (count) send_update(random_update());
  endtask

  // Servo extremes, lamps, every mode, chirp starts and expiry, time wrap
  task automatic test_servo_and_lamps();
    update_t u;
    sender_gaps = 1'b0;
    // first update only samples the source
    send_update(quiet_update(32'd0, 16'sd0, 16'h1234));
    send_update(quiet_update(32'd100, vasd_pkg::STEER_W'(vasd_pkg::MAX_STEER), 16'h4321));
    send_update(quiet_update(32'd260, -vasd_pkg::STEER_W'(vasd_pkg::MAX_STEER), 16'h4321));
    u = quiet_update(32'd410, 16'sh7FFF, 16'h4321);
    u.left_turn = 1'b1;
    send_update(u);
    u = quiet_update(32'd500, 16'sh8000, 16'h4321);
    u.right_turn = 1'b1;
    u.hazard = 1'b1;
    send_update(u);
    u = quiet_update(32'd600, 16'sd1, 16'h4321);
    u.estop = 1'b1;
    send_update(u);
    u = quiet_update(32'd700, -16'sd1, 16'h4321);
    u.aeb = 1'b1;
    send_update(u);
    for (int m = 1; m < 8; m++) begin
      u = quiet_update(32'd750 + 32'(m) * 37,
                       vasd_pkg::STEER_W'(vasd_pkg::MAX_STEER + 1) - vasd_pkg::STEER_W'(m),
                       16'h4321);
      u.mode = vasd_pkg::MODE_W'(m);
      send_update(u);
    end
    // chirp requested while degraded does not expire until the chirp branch rules
    u = quiet_update(32'd1300, 16'sd15, 16'h4321);
    u.degraded = 1'b1;
    u.req = 1'b1;
    send_update(u);
    send_update(quiet_update(32'd1400, -16'sd15, 16'h4321));
    // chirp end wraps past zero
    u = quiet_update(32'hFFFF_FFF0, 16'sd0, 16'h4321);
    u.req = 1'b1;
    send_update(u);
    send_update(quiet_update(32'h0000_0010, 16'sd0, 16'h4321));
    send_update(quiet_update(32'h0000_0100, 16'sd0, 16'h4321));
  endtask

  // Zero periods and widest settings with saturating servo widths
  task automatic test_register_corners();
    update_t u;
    set_registers(16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    sender_gaps = 1'b0;
    send_update(quiet_update(cur_now + 1, -vasd_pkg::STEER_W'(vasd_pkg::MAX_STEER), cur_src));
    u = quiet_update(cur_now + 1, vasd_pkg::STEER_W'(vasd_pkg::MAX_STEER), cur_src);
    u.estop = 1'b1;
    u.hazard = 1'b1;
    send_update(u);
    u = quiet_update(cur_now + 1, 16'sd0, cur_src);
    u.degraded = 1'b1;
    send_update(u);
    u = quiet_update(cur_now + 1, 16'sd0, cur_src);
    u.req = 1'b1;
    send_update(u);
    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF);
    sender_gaps = 1'b0;
    send_update(quiet_update(cur_now + 5, vasd_pkg::STEER_W'(vasd_pkg::MAX_STEER), cur_src));
    send_update(quiet_update(cur_now + 5, -vasd_pkg::STEER_W'(vasd_pkg::MAX_STEER),
                             cur_src ^ 16'h00FF));
    u = quiet_update(cur_now + 5, 16'sd3, cur_src);
    u.aeb = 1'b1;
    send_update(u);
    u = quiet_update(cur_now + 40000, 16'sd3, cur_src);
    u.mode = vasd_pkg::MODE_MIN_RISK;
    send_update(u);
  endtask

  task automatic test_random_default();
    set_registers(vasd_pkg::RST_SERVO_MID, 16'(vasd_pkg::RST_SERVO_SPAN),
                  vasd_pkg::RST_BLINK_HALF, vasd_pkg::RST_CHIRP,
                  16'(vasd_pkg::RST_CRIT_ON), 16'(vasd_pkg::RST_CRIT_OFF),
                  16'(vasd_pkg::RST_DEGR_ON), 16'(vasd_pkg::RST_DEGR_OFF));
    run_updates(300, 1'b1, 20, 120);
  endtask

  task automatic test_random_registers();
    repeat (3) begin
      set_registers(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      run_updates(100, 1'b1, 25, 400);
    end
  endtask

  // Short periods with fine time steps; pause midway until all results are back
  task automatic test_fast_timing();
    set_registers(16'd1500, 16'd500, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 12)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
    run_updates(125, 1'b0, 30, 6);
    wait_all_results();
    run_updates(125, 1'b1, 30, 6);
  endtask

  task automatic test_extreme_registers();
    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF);
    run_updates(200, 1'b1, 40, 30000);
    set_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_updates(100, 1'b1, 40, 50);
  endtask

  // No alarms, so chirps start and run out on their own
  task automatic test_quiet_chirps();
    set_registers(16'd1500, 16'd500, 16'd200, 16'd90, 16'd100, 16'd100, 16'd800, 16'd400);
    run_updates(200, 1'b1, 0, 40);
  endtask

  task automatic check_field(string fname, int exp_val, int got_val);
    if (exp_val != got_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at result %0d: expected %0d, got %0d",
                 fname, results_checked, exp_val, got_val);
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("servo_us", want.servo_us, servo_us);
        check_field("light_left", want.light_left, light_left);
        check_field("light_right", want.light_right, light_right);
        check_field("buzzer_on", want.buzzer_on, buzzer_on);
        check_field("run_led", want.run_led, run_led);
        check_field("fault_led", want.fault_led, fault_led);
      end
      results_checked++;
    end
  end

  // Receiver stall: rotate through open, random, periodic and heavy stretches
  always @(negedge clk) begin
    stall_tick++;
    case ((stall_tick / 400) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= $urandom_range(0, 2) == 0;
      2:       out_stall <= (stall_tick % 11) < 4;
      default: out_stall <= $urandom_range(0, 2) != 0;
    endcase
  end

  // Stop the run if no request moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no request moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("tb_vehicle_annunciator_servo_drive: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    now_ms = '0;
    steer = '0;
    hazard = 1'b0;
    left_turn = 1'b0;
    right_turn = 1'b0;
    estop = 1'b0;
    aeb_floor = 1'b0;
    degraded = 1'b0;
    system_mode = '0;
    source_id = '0;
    chirp_request = 1'b0;
    mid_us = vasd_pkg::RST_SERVO_MID;
    half_span = vasd_pkg::RST_SERVO_SPAN;
    blink_half = vasd_pkg::RST_BLINK_HALF;
    chirp_len = vasd_pkg::RST_CHIRP;
    crit_on = vasd_pkg::RST_CRIT_ON;
    crit_off = vasd_pkg::RST_CRIT_OFF;
    degr_on = vasd_pkg::RST_DEGR_ON;
    degr_off = vasd_pkg::RST_DEGR_OFF;
    blink_ref = '0;
    blink_phase = 1'b0;
    chirp_end = '0;
    chirp_on = 1'b0;
    prev_src = '0;
    source_seen = 1'b0;
    cur_now = '0;
    cur_src = '0;
    step_max = 120;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_servo_and_lamps();
    test_register_corners();
    test_random_default();
    test_random_registers();
    test_fast_timing();
    test_extreme_registers();
    test_quiet_chirps();

    wait_all_results();
    repeat (60) @(posedge clk);
    $display("covered %0d updates and %0d results over %0d register loads",
             updates_sent, results_checked, register_sets);
    $display("field mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_vehicle_annunciator_servo_drive: clean");
    end else begin
      $display("tb_vehicle_annunciator_servo_drive: errors");
    end
    $finish;
  end

endmodule
